// ----- rtl/dssr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssr_pkg
// Shared widths, item codes and direction codes for the 4-connected digital
// straight segment recognizer.
// ----------------------------------------------------------------------------
package dssr_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Fixed result field widths
    localparam int SLOPE_W  = 17;
    localparam int OFFSET_W = 34;
    localparam int DIR_W    = 3;

    // Item function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_APPEND = 1'b1;

    // Step directions, two's complement so that negation gives the opposite
    typedef logic signed [DIR_W-1:0] t_dir;

    localparam t_dir DIR_NONE  = 3'sd0;
    localparam t_dir DIR_POS_X = 3'sd1;
    localparam t_dir DIR_NEG_X = -3'sd1;
    localparam t_dir DIR_POS_Y = 3'sd2;
    localparam t_dir DIR_NEG_Y = -3'sd2;

endpackage

// ----- rtl/dssr_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssr_update
// Segment state and its registered update: start from two points or append a
// point at the right end, with the remainder test and leaning point moves.
// ----------------------------------------------------------------------------
module dssr_update #(
    parameter int COORD_BITS = dssr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_func,
    input  logic signed [COORD_BITS-1:0] i_anchor_x,
    input  logic signed [COORD_BITS-1:0] i_anchor_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_accepted,
    output logic signed [COORD_BITS:0]   o_coef_a,
    output logic signed [COORD_BITS:0]   o_coef_b,
    output logic signed [COORD_BITS-1:0] o_lower_right_x,
    output logic signed [COORD_BITS-1:0] o_lower_right_y,
    output dssr_pkg::t_dir               o_main_dir,
    output dssr_pkg::t_dir               o_second_dir
);

    localparam int AW = COORD_BITS + 1;     // coefficient and difference width
    localparam int PW = 2 * AW;             // product width
    localparam int HW = PW + 1;             // remainder width

    localparam logic signed [AW-1:0]         L_ONE   = AW'(1);
    localparam logic signed [AW-1:0]         L_MONE  = '1;
    localparam logic signed [COORD_BITS-1:0] C_ONE   = COORD_BITS'(1);
    localparam logic signed [HW-1:0]         H_ZERO  = '0;
    localparam logic signed [HW-1:0]         H_ONE   = HW'(1);
    localparam logic signed [HW-1:0]         H_MONE  = '1;

    function automatic dssr_pkg::t_dir f_step_dir(
        input logic signed [AW-1:0] dx,
        input logic signed [AW-1:0] dy
    );
        dssr_pkg::t_dir d;
        d = dssr_pkg::DIR_NONE;
        if (dy == '0 && dx == L_ONE) begin
            d = dssr_pkg::DIR_POS_X;
        end else if (dy == '0 && dx == L_MONE) begin
            d = dssr_pkg::DIR_NEG_X;
        end else if (dx == '0 && dy == L_ONE) begin
            d = dssr_pkg::DIR_POS_Y;
        end else if (dx == '0 && dy == L_MONE) begin
            d = dssr_pkg::DIR_NEG_Y;
        end
        return d;
    endfunction

    logic signed [COORD_BITS-1:0] r_end_x, r_end_y, n_end_x, n_end_y;
    logic signed [COORD_BITS-1:0] r_ll_x, r_ll_y, n_ll_x, n_ll_y;
    logic signed [COORD_BITS-1:0] r_lr_x, r_lr_y, n_lr_x, n_lr_y;
    logic signed [COORD_BITS-1:0] r_ul_x, r_ul_y, n_ul_x, n_ul_y;
    logic signed [COORD_BITS-1:0] r_ur_x, r_ur_y, n_ur_x, n_ur_y;
    logic signed [AW-1:0]         r_coef_a, r_coef_b, n_coef_a, n_coef_b;
    dssr_pkg::t_dir               r_main_dir, r_second_dir, n_main_dir, n_second_dir;
    logic                         r_accepted, n_accepted;

    dssr_pkg::t_dir       w_start_dir, w_app_dir, w_main_neg;
    logic signed [AW-1:0] w_dx_lr, w_dy_lr, w_abs_a, w_abs_b;
    logic signed [PW-1:0] w_prod_b, w_prod_a;
    logic signed [HW-1:0] w_rem, w_sum, w_sum_m1;
    logic                 w_turn_ok;

    assign w_start_dir = f_step_dir(AW'(i_point_x) - AW'(i_anchor_x),
                                    AW'(i_point_y) - AW'(i_anchor_y));
    assign w_app_dir   = f_step_dir(AW'(i_point_x) - AW'(r_end_x),
                                    AW'(i_point_y) - AW'(r_end_y));
    assign w_main_neg  = -r_main_dir;

    // Remainder b*x - a*y + c, with c taken from the lower right leaning point
    assign w_dx_lr  = AW'(i_point_x) - AW'(r_lr_x);
    assign w_dy_lr  = AW'(i_point_y) - AW'(r_lr_y);
    assign w_prod_b = r_coef_b * w_dx_lr;
    assign w_prod_a = r_coef_a * w_dy_lr;
    assign w_rem    = HW'(w_prod_b) - HW'(w_prod_a);

    assign w_abs_a  = r_coef_a[AW-1] ? -r_coef_a : r_coef_a;
    assign w_abs_b  = r_coef_b[AW-1] ? -r_coef_b : r_coef_b;
    assign w_sum    = HW'(w_abs_a) + HW'(w_abs_b);
    assign w_sum_m1 = w_sum - H_ONE;

    assign w_turn_ok = (r_second_dir == dssr_pkg::DIR_NONE) ||
                       (w_app_dir == r_main_dir) || (w_app_dir == r_second_dir);

    always_comb begin
        n_end_x      = r_end_x;
        n_end_y      = r_end_y;
        n_ll_x       = r_ll_x;
        n_ll_y       = r_ll_y;
        n_lr_x       = r_lr_x;
        n_lr_y       = r_lr_y;
        n_ul_x       = r_ul_x;
        n_ul_y       = r_ul_y;
        n_ur_x       = r_ur_x;
        n_ur_y       = r_ur_y;
        n_coef_a     = r_coef_a;
        n_coef_b     = r_coef_b;
        n_main_dir   = r_main_dir;
        n_second_dir = r_second_dir;
        n_accepted   = 1'b0;

        if (i_func == dssr_pkg::FUNC_START) begin
            if (w_start_dir != dssr_pkg::DIR_NONE) begin
                n_accepted   = 1'b1;
                n_ll_x       = i_anchor_x;
                n_ll_y       = i_anchor_y;
                n_ul_x       = i_anchor_x;
                n_ul_y       = i_anchor_y;
                n_lr_x       = i_point_x;
                n_lr_y       = i_point_y;
                n_ur_x       = i_point_x;
                n_ur_y       = i_point_y;
                n_main_dir   = w_start_dir;
                n_second_dir = dssr_pkg::DIR_NONE;
                n_coef_a     = AW'(i_point_x) - AW'(i_anchor_x);
                n_coef_b     = AW'(i_point_y) - AW'(i_anchor_y);
            end
        end else if (w_app_dir != dssr_pkg::DIR_NONE) begin
            if (r_second_dir == dssr_pkg::DIR_NONE &&
                (w_app_dir == r_main_dir || w_app_dir == w_main_neg)) begin
                // still straight: right leaning points follow the end point
                if (w_app_dir == r_main_dir) begin
                    n_accepted = 1'b1;
                    case (r_main_dir)
                        dssr_pkg::DIR_POS_X: begin
                            n_lr_x = r_lr_x + C_ONE;
                            n_ur_x = r_ur_x + C_ONE;
                        end
                        dssr_pkg::DIR_NEG_X: begin
                            n_lr_x = r_lr_x - C_ONE;
                            n_ur_x = r_ur_x - C_ONE;
                        end
                        dssr_pkg::DIR_POS_Y: begin
                            n_lr_y = r_lr_y + C_ONE;
                            n_ur_y = r_ur_y + C_ONE;
                        end
                        dssr_pkg::DIR_NEG_Y: begin
                            n_lr_y = r_lr_y - C_ONE;
                            n_ur_y = r_ur_y - C_ONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                // first turn is recorded even if the remainder test fails
                if (r_second_dir == dssr_pkg::DIR_NONE) begin
                    n_second_dir = w_app_dir;
                end
                if (w_turn_ok) begin
                    if (w_rem > H_ZERO && w_rem < w_sum_m1) begin
                        n_accepted = 1'b1;
                    end else if (w_rem == '0) begin
                        n_accepted = 1'b1;
                        n_lr_x     = i_point_x;
                        n_lr_y     = i_point_y;
                    end else if (w_rem == w_sum_m1) begin
                        n_accepted = 1'b1;
                        n_ur_x     = i_point_x;
                        n_ur_y     = i_point_y;
                    end else if (w_rem == H_MONE) begin
                        n_accepted = 1'b1;
                        n_lr_x     = i_point_x;
                        n_lr_y     = i_point_y;
                        n_ul_x     = r_ur_x;
                        n_ul_y     = r_ur_y;
                        n_coef_a   = AW'(i_point_x) - AW'(r_ll_x);
                        n_coef_b   = AW'(i_point_y) - AW'(r_ll_y);
                    end else if (w_rem == w_sum) begin
                        n_accepted = 1'b1;
                        n_ur_x     = i_point_x;
                        n_ur_y     = i_point_y;
                        n_ll_x     = r_lr_x;
                        n_ll_y     = r_lr_y;
                        n_coef_a   = AW'(i_point_x) - AW'(r_ul_x);
                        n_coef_b   = AW'(i_point_y) - AW'(r_ul_y);
                    end
                end
            end
        end

        if (n_accepted) begin
            n_end_x = i_point_x;
            n_end_y = i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_ll_x       <= '0;
            r_ll_y       <= '0;
            r_lr_x       <= '0;
            r_lr_y       <= '0;
            r_ul_x       <= '0;
            r_ul_y       <= '0;
            r_ur_x       <= '0;
            r_ur_y       <= '0;
            r_coef_a     <= '0;
            r_coef_b     <= '0;
            r_main_dir   <= dssr_pkg::DIR_NONE;
            r_second_dir <= dssr_pkg::DIR_NONE;
        end else if (i_step) begin
            r_end_x      <= n_end_x;
            r_end_y      <= n_end_y;
            r_ll_x       <= n_ll_x;
            r_ll_y       <= n_ll_y;
            r_lr_x       <= n_lr_x;
            r_lr_y       <= n_lr_y;
            r_ul_x       <= n_ul_x;
            r_ul_y       <= n_ul_y;
            r_ur_x       <= n_ur_x;
            r_ur_y       <= n_ur_y;
            r_coef_a     <= n_coef_a;
            r_coef_b     <= n_coef_b;
            r_main_dir   <= n_main_dir;
            r_second_dir <= n_second_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_accepted <= n_accepted;
        end
    end

    assign o_accepted      = r_accepted;
    assign o_coef_a        = r_coef_a;
    assign o_coef_b        = r_coef_b;
    assign o_lower_right_x = r_lr_x;
    assign o_lower_right_y = r_lr_y;
    assign o_main_dir      = r_main_dir;
    assign o_second_dir    = r_second_dir;

endmodule

// ----- rtl/digital_straight_segment_recognizer_core.sv -----
`timescale 1ns / 1ps
// Pipeline: input register, segment update, then offset multiply into the
// result register that drives result valid.
// Throughput: one item per cycle while the output is not stalled; the segment
// update (remainder multiply and compare against the current line) is combinational.
// Reset: synchronous; clears the segment to the all-zero line and empties
// the pipeline. No items are held off after reset.
// ----------------------------------------------------------------------------
// digital_straight_segment_recognizer_core
// Grows a 4-connected digital straight segment one point per transaction and
// reports the line (a, b, c) and the step directions after each item.
// ----------------------------------------------------------------------------
module digital_straight_segment_recognizer_core #(
    parameter int COORD_BITS = dssr_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic signed [COORD_BITS-1:0]        i_anchor_x,
    input  logic signed [COORD_BITS-1:0]        i_anchor_y,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_accepted,
    output logic signed [dssr_pkg::SLOPE_W-1:0]  o_slope_a,
    output logic signed [dssr_pkg::SLOPE_W-1:0]  o_slope_b,
    output logic signed [dssr_pkg::OFFSET_W-1:0] o_offset_c,
    output dssr_pkg::t_dir                      o_out_dir_first,
    output dssr_pkg::t_dir                      o_out_dir_second
);

    localparam int AW = COORD_BITS + 1;
    localparam int PW = AW + COORD_BITS;
    localparam int CW = PW + 1;
    localparam int SW = dssr_pkg::SLOPE_W;
    localparam int OW = dssr_pkg::OFFSET_W;

    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic signed [SW-1:0] S_MONE = '1;

    // input register
    logic                         r_in_valid;
    logic                         r_func;
    logic signed [COORD_BITS-1:0] r_anchor_x, r_anchor_y, r_point_x, r_point_y;

    // segment stage valid, result register
    logic                  r_s1_valid;
    logic                  r_out_valid;
    logic                  r_out_accepted;
    logic signed [SW-1:0]  r_out_a, r_out_b;
    logic signed [OW-1:0]  r_out_c;
    dssr_pkg::t_dir        r_out_dir1, r_out_dir2;

    logic w_s0_ld, w_s1_ld, w_s2_ld, w_step;

    logic                         w_accepted;
    logic signed [AW-1:0]         w_coef_a, w_coef_b;
    logic signed [COORD_BITS-1:0] w_lr_x, w_lr_y;
    dssr_pkg::t_dir               w_main_dir, w_second_dir;

    logic signed [PW-1:0] w_prod_ay, w_prod_bx;
    logic signed [CW-1:0] w_offset;

    assign w_s2_ld = !r_out_valid || !i_out_stall;
    assign w_s1_ld = !r_s1_valid || w_s2_ld;
    assign w_s0_ld = !r_in_valid || w_s1_ld;
    assign w_step  = w_s1_ld && r_in_valid;

    assign o_in_stall = !w_s0_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s0_ld) begin
                r_in_valid <= i_in_valid;
            end
            if (w_s1_ld) begin
                r_s1_valid <= r_in_valid;
            end
            if (w_s2_ld) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_ld && i_in_valid) begin
            r_func     <= i_func;
            r_anchor_x <= i_anchor_x;
            r_anchor_y <= i_anchor_y;
            r_point_x  <= i_point_x;
            r_point_y  <= i_point_y;
        end
    end

    dssr_update #(
        .COORD_BITS (COORD_BITS)
    ) u_update (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_func          (r_func),
        .i_anchor_x      (r_anchor_x),
        .i_anchor_y      (r_anchor_y),
        .i_point_x       (r_point_x),
        .i_point_y       (r_point_y),
        .o_accepted      (w_accepted),
        .o_coef_a        (w_coef_a),
        .o_coef_b        (w_coef_b),
        .o_lower_right_x (w_lr_x),
        .o_lower_right_y (w_lr_y),
        .o_main_dir      (w_main_dir),
        .o_second_dir    (w_second_dir)
    );

    // c = a * lr.y - b * lr.x from the updated segment
    assign w_prod_ay = w_coef_a * w_lr_y;
    assign w_prod_bx = w_coef_b * w_lr_x;
    assign w_offset  = CW'(w_prod_ay) - CW'(w_prod_bx);

    always_ff @(posedge i_clk) begin
        if (w_s2_ld && r_s1_valid) begin
            r_out_accepted <= w_accepted;
            r_out_a        <= SW'(w_coef_a);
            r_out_b        <= SW'(w_coef_b);
            r_out_c        <= OW'(w_offset);
            r_out_dir1     <= w_main_dir;
            r_out_dir2     <= w_second_dir;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_accepted;
    assign o_slope_a        = r_out_a;
    assign o_slope_b        = r_out_b;
    assign o_offset_c       = r_out_c;
    assign o_out_dir_first  = r_out_dir1;
    assign o_out_dir_second = r_out_dir2;

    // segment must hold while its transaction waits for the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_ld) |=> ($stable(w_coef_a) && $stable(w_coef_b) &&
                                      $stable(w_lr_x) && $stable(w_lr_y)))
        else $error("segment state changed while stage held");

    // input side stalls only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // straight segment keeps the unit line of its first step
    a_straight_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_dir_first != dssr_pkg::DIR_NONE &&
         o_out_dir_second == dssr_pkg::DIR_NONE) |->
        (((o_slope_a == S_ONE || o_slope_a == S_MONE) && o_slope_b == '0) ||
         (o_slope_a == '0 && (o_slope_b == S_ONE || o_slope_b == S_MONE))))
        else $error("straight segment with non-unit line");

    // second direction is never the first one or its opposite
    a_dir_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_dir_first != dssr_pkg::DIR_NONE) |->
        (o_out_dir_second != o_out_dir_first &&
         o_out_dir_second != dssr_pkg::t_dir'(-o_out_dir_first)))
        else $error("second direction conflicts with first");

endmodule

// ----- sim/digital_straight_segment_recognizer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_straight_segment_recognizer_core_tb
// Drives start and append transactions into the segment recognizer: a
// directed set of corner cases, then random digital lines with noise. A
// scoreboard tracks the segment (line, leaning points, directions) on its own
// and checks every result transaction in order, under random idle and stall.
// ----------------------------------------------------------------------------
module digital_straight_segment_recognizer_core_tb;

    localparam int CB         = dssr_pkg::COORD_BITS_DEF;
    localparam int CLK_PERIOD = 12;

    typedef logic signed [CB-1:0] t_coord;

    localparam t_coord C_MAX = t_coord'(2 ** (CB - 1) - 1);
    localparam t_coord C_MIN = t_coord'(-(2 ** (CB - 1)));

    typedef struct {
        longint x;
        longint y;
    } t_grid_pt;

    typedef struct {
        logic                                 accepted;
        logic signed [dssr_pkg::SLOPE_W-1:0]  slope_a;
        logic signed [dssr_pkg::SLOPE_W-1:0]  slope_b;
        logic signed [dssr_pkg::OFFSET_W-1:0] offset_c;
        dssr_pkg::t_dir                       dir_first;
        dssr_pkg::t_dir                       dir_second;
    } t_seg_result;

    function automatic t_coord crd(int v);
        return t_coord'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the segment, expected results in arrival order
    // ------------------------------------------------------------------------
    class segment_scoreboard;
        t_grid_pt       end_pt, low_left, low_right, up_left, up_right;
        dssr_pkg::t_dir dir_main, dir_turn;
        longint         line_a, line_b, line_c;
        t_seg_result    expected_q[$];
        int             errors;

        function new();
            t_grid_pt origin;
            origin.x  = 0;
            origin.y  = 0;
            end_pt    = origin;
            low_left  = origin;
            low_right = origin;
            up_left   = origin;
            up_right  = origin;
            dir_main  = dssr_pkg::DIR_NONE;
            dir_turn  = dssr_pkg::DIR_NONE;
            line_a    = 0;
            line_b    = 0;
            line_c    = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint wrap_coord(longint v);
            t_coord t;
            t = v[CB-1:0];
            return longint'(t);
        endfunction

        function dssr_pkg::t_dir step_between(t_grid_pt p, t_grid_pt q);
            longint dx, dy;
            dx = q.x - p.x;
            dy = q.y - p.y;
            if (dy == 0 && dx == 1)  return dssr_pkg::DIR_POS_X;
            if (dy == 0 && dx == -1) return dssr_pkg::DIR_NEG_X;
            if (dx == 0 && dy == 1)  return dssr_pkg::DIR_POS_Y;
            if (dx == 0 && dy == -1) return dssr_pkg::DIR_NEG_Y;
            return dssr_pkg::DIR_NONE;
        endfunction

        function t_grid_pt advance(t_grid_pt p, dssr_pkg::t_dir d);
            case (d)
                dssr_pkg::DIR_POS_X: p.x = p.x + 1;
                dssr_pkg::DIR_NEG_X: p.x = p.x - 1;
                dssr_pkg::DIR_POS_Y: p.y = p.y + 1;
                dssr_pkg::DIR_NEG_Y: p.y = p.y - 1;
                default: ;
            endcase
            p.x = wrap_coord(p.x);
            p.y = wrap_coord(p.y);
            return p;
        endfunction

        // c from the lower right leaning point, 64-bit wraparound
        function void update_offset();
            line_c = line_a * low_right.y - line_b * low_right.x;
        endfunction

        function bit start_segment(t_grid_pt p1, t_grid_pt p2);
            dssr_pkg::t_dir d;
            d = step_between(p1, p2);
            if (d == dssr_pkg::DIR_NONE) return 1'b0;
            end_pt    = p2;
            low_left  = p1;
            up_left   = p1;
            low_right = p2;
            up_right  = p2;
            dir_main  = d;
            dir_turn  = dssr_pkg::DIR_NONE;
            line_a    = p2.x - p1.x;
            line_b    = p2.y - p1.y;
            update_offset();
            return 1'b1;
        endfunction

        function bit append_point(t_grid_pt p);
            dssr_pkg::t_dir d, back;
            longint         h, s;
            d    = step_between(end_pt, p);
            back = -dir_main;
            if (d == dssr_pkg::DIR_NONE) return 1'b0;

            if (dir_turn == dssr_pkg::DIR_NONE && (d == dir_main || d == back)) begin
                if (d == back) return 1'b0;
                low_right = advance(low_right, dir_main);
                up_right  = advance(up_right, dir_main);
                end_pt    = p;
                return 1'b1;
            end

            // first turn sticks even if the remainder test fails below
            if (dir_turn == dssr_pkg::DIR_NONE)
                dir_turn = d;
            else if (d != dir_main && d != dir_turn)
                return 1'b0;

            h = line_b * p.x - line_a * p.y + line_c;
            s = (line_a < 0 ? -line_a : line_a) + (line_b < 0 ? -line_b : line_b);

            if (h > 0 && h < s - 1) begin
            end else if (h == 0) begin
                low_right = p;
            end else if (h == s - 1) begin
                up_right = p;
            end else if (h == -1) begin
                low_right = p;
                up_left   = up_right;
                line_a    = p.x - low_left.x;
                line_b    = p.y - low_left.y;
                update_offset();
            end else if (h == s) begin
                up_right = p;
                low_left = low_right;
                line_a   = p.x - up_left.x;
                line_b   = p.y - up_left.y;
                update_offset();
            end else begin
                return 1'b0;
            end
            end_pt = p;
            return 1'b1;
        endfunction

        function void note_item(logic f, t_coord ax, t_coord ay, t_coord px, t_coord py);
            t_grid_pt    anc, pnt;
            t_seg_result r;
            anc.x = longint'(ax);
            anc.y = longint'(ay);
            pnt.x = longint'(px);
            pnt.y = longint'(py);
            if (f == dssr_pkg::FUNC_START)
                r.accepted = start_segment(anc, pnt);
            else
                r.accepted = append_point(pnt);
            r.slope_a    = line_a[dssr_pkg::SLOPE_W-1:0];
            r.slope_b    = line_b[dssr_pkg::SLOPE_W-1:0];
            r.offset_c   = line_c[dssr_pkg::OFFSET_W-1:0];
            r.dir_first  = dir_main;
            r.dir_second = dir_turn;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_seg_result got);
            t_seg_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result acc=%0d a=%0d b=%0d c=%0d d1=%0d d2=%0d",
                         $time, got.accepted, got.slope_a, got.slope_b, got.offset_c,
                         got.dir_first, got.dir_second);
                return;
            end
            e = expected_q.pop_front();
            if (got.accepted !== e.accepted || got.slope_a !== e.slope_a ||
                got.slope_b !== e.slope_b || got.offset_c !== e.offset_c ||
                got.dir_first !== e.dir_first || got.dir_second !== e.dir_second) begin
                errors++;
                $display("%0t: mismatch expected acc=%0d a=%0d b=%0d c=%0d d1=%0d d2=%0d",
                         $time, e.accepted, e.slope_a, e.slope_b, e.offset_c,
                         e.dir_first, e.dir_second);
                $display("%0t:          actual   acc=%0d a=%0d b=%0d c=%0d d1=%0d d2=%0d",
                         $time, got.accepted, got.slope_a, got.slope_b, got.offset_c,
                         got.dir_first, got.dir_second);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                                 i_clk     = 1'b0;
    logic                                 i_rst_n   = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic                                 item_func = dssr_pkg::FUNC_START;
    t_coord                               anchor_x  = '0;
    t_coord                               anchor_y  = '0;
    t_coord                               point_x   = '0;
    t_coord                               point_y   = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 res_accepted;
    logic signed [dssr_pkg::SLOPE_W-1:0]  res_slope_a;
    logic signed [dssr_pkg::SLOPE_W-1:0]  res_slope_b;
    logic signed [dssr_pkg::OFFSET_W-1:0] res_offset_c;
    dssr_pkg::t_dir                       res_dir_first;
    dssr_pkg::t_dir                       res_dir_second;

    int in_idle_pct  = 16;
    int out_idle_pct = 55;
    int items_sent   = 0;

    segment_scoreboard sb;

    digital_straight_segment_recognizer_core #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (item_func),
        .i_anchor_x      (anchor_x),
        .i_anchor_y      (anchor_y),
        .i_point_x       (point_x),
        .i_point_y       (point_y),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_accepted      (res_accepted),
        .o_slope_a       (res_slope_a),
        .o_slope_b       (res_slope_b),
        .o_offset_c      (res_offset_c),
        .o_out_dir_first (res_dir_first),
        .o_out_dir_second(res_dir_second)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_seg_result got;
        if (i_rst_n && out_valid && !out_stall) begin
            got.accepted   = res_accepted;
            got.slope_a    = res_slope_a;
            got.slope_b    = res_slope_b;
            got.offset_c   = res_offset_c;
            got.dir_first  = res_dir_first;
            got.dir_second = res_dir_second;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic f, t_coord ax, t_coord ay, t_coord px, t_coord py);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        item_func <= f;
        anchor_x  <= ax;
        anchor_y  <= ay;
        point_x   <= px;
        point_y   <= py;
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.note_item(f, ax, ay, px, py);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic void step_coord(dssr_pkg::t_dir d, inout t_coord x, inout t_coord y);
        case (d)
            dssr_pkg::DIR_POS_X: x = crd(x + 1);
            dssr_pkg::DIR_NEG_X: x = crd(x - 1);
            dssr_pkg::DIR_POS_Y: y = crd(y + 1);
            dssr_pkg::DIR_NEG_Y: y = crd(y - 1);
            default: ;
        endcase
    endfunction

    // One digital line of slope v/u along a random axis, with some noise
    task automatic send_line_run(int n_appends);
        dssr_pkg::t_dir axis_dirs[4] = '{dssr_pkg::DIR_POS_X, dssr_pkg::DIR_NEG_X,
                                         dssr_pkg::DIR_POS_Y, dssr_pkg::DIR_NEG_Y};
        t_coord         ax, ay, cx, cy, px, py;
        dssr_pkg::t_dir major, minor, pick;
        int             u, v, n_major, n_minor, r;
        ax = t_coord'($urandom);
        ay = t_coord'($urandom);
        case ($urandom_range(7))
            0: ax = C_MAX;
            1: ax = C_MIN;
            2: ay = C_MAX;
            3: ay = C_MIN;
            default: ;
        endcase
        r     = $urandom_range(3);
        major = axis_dirs[r];
        minor = axis_dirs[(r < 2 ? 2 : 0) + $urandom_range(1)];
        u     = $urandom_range(9, 1);
        v     = $urandom_range(u, 0);
        cx    = ax;
        cy    = ay;
        step_coord(major, cx, cy);
        send_item(dssr_pkg::FUNC_START, ax, ay, cx, cy);
        n_major = 1;
        n_minor = 0;
        for (int k = 0; k < n_appends; k++) begin
            if ($urandom_range(99) < 85) begin
                if ((n_minor + 1) * u <= n_major * v) begin
                    pick = minor;
                    n_minor++;
                end else begin
                    pick = major;
                    n_major++;
                end
                step_coord(pick, cx, cy);
                send_item(dssr_pkg::FUNC_APPEND, t_coord'($urandom), t_coord'($urandom),
                          cx, cy);
            end else begin
                px = cx;
                py = cy;
                case ($urandom_range(3))
                    0: step_coord(-major, px, py);   // step back
                    1: step_coord(-minor, px, py);   // third direction
                    2: begin
                        px = t_coord'($urandom);
                        py = t_coord'($urandom);
                    end
                    default: ;                        // end point again
                endcase
                send_item(dssr_pkg::FUNC_APPEND, t_coord'($urandom), t_coord'($urandom),
                          px, py);
            end
        end
    endtask

    initial begin
        t_coord jx, jy, kx, ky;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // append on the reset state, then a third direction
        send_item(dssr_pkg::FUNC_APPEND, C_MAX, C_MIN, crd(1), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, C_MIN, C_MAX, crd(2), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(2), crd(1));
        // starts that are not 4-adjacent
        send_item(dssr_pkg::FUNC_START, crd(0), crd(0), crd(0), crd(0));
        send_item(dssr_pkg::FUNC_START, crd(5), crd(5), crd(7), crd(5));
        // bottom corner of the grid: step back, straight, turn
        send_item(dssr_pkg::FUNC_START, C_MIN, C_MIN, crd(C_MIN + 1), C_MIN);
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), C_MIN, C_MIN);
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(C_MIN + 2), C_MIN);
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(C_MIN + 2), crd(C_MIN + 1));
        // top corner, and neighbors only across the wrap
        send_item(dssr_pkg::FUNC_START, C_MAX, C_MAX, C_MAX, crd(C_MAX - 1));
        send_item(dssr_pkg::FUNC_APPEND, C_MAX, C_MAX, C_MAX, crd(C_MAX - 2));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), C_MIN, crd(C_MAX - 2));
        send_item(dssr_pkg::FUNC_START, crd(C_MAX - 1), crd(0), C_MAX, crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), C_MIN, crd(0));
        // remainder -1 update, remainder out of range, inside, third direction
        send_item(dssr_pkg::FUNC_START, crd(0), crd(0), crd(1), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(2), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(3), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(3), crd(1));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(3), crd(2));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(4), crd(1));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(4), crd(0));
        // remainder equal to |a|+|b|
        send_item(dssr_pkg::FUNC_START, crd(-1), crd(0), crd(0), crd(0));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(0), crd(-1));
        send_item(dssr_pkg::FUNC_APPEND, crd(0), crd(0), crd(1), crd(-1));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin in_idle_pct = 16; out_idle_pct = 55; end
                1: begin in_idle_pct = 55; out_idle_pct = 16; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            while (items_sent < (phase + 1) * 380) begin
                if ($urandom_range(9) == 0) begin
                    jx = t_coord'($urandom);
                    jy = t_coord'($urandom);
                    kx = jx;
                    ky = jy;
                    case ($urandom_range(2))
                        0: begin kx = t_coord'($urandom); ky = t_coord'($urandom); end
                        1: kx = crd(jx + 2);
                        default: ;
                    endcase
                    send_item(dssr_pkg::FUNC_START, jx, jy, kx, ky);
                end else begin
                    send_line_run($urandom_range(40, 1));
                end
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("digital_straight_segment_recognizer_core_tb: PASS");
        else
            $display("digital_straight_segment_recognizer_core_tb: FAIL");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("digital_straight_segment_recognizer_core_tb: FAIL");
        $finish;
    end

endmodule
